### rtl/fswt_pkg.sv
// Shared types, register codes and reset values for the FSK square-wave transmitter.
// Used by every module of the block; it depends on nothing.
package fswt_pkg;

  localparam int BITS_PER_SYMBOL = 8;
  localparam int BIT_IDX_W       = 3;
  localparam int BOUND_W         = 4;
  localparam int TIME_W          = 16;

  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [BIT_IDX_W-1:0] bit_idx_t;
  typedef logic [BOUND_W-1:0]   bound_t;
  typedef logic [2:0]           cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_MARK_HIGH   = 3'd0;
  localparam cfg_idx_t REG_MARK_LOW    = 3'd1;
  localparam cfg_idx_t REG_MARK_CYCLES = 3'd2;
  localparam cfg_idx_t REG_SPACE_HIGH  = 3'd3;
  localparam cfg_idx_t REG_SPACE_LOW   = 3'd4;
  localparam cfg_idx_t REG_SPACE_CYC   = 3'd5;

  // Register reset values.
  localparam time_t RST_MARK_HIGH   = 16'd416;
  localparam time_t RST_MARK_LOW    = 16'd417;
  localparam time_t RST_MARK_CYCLES = 16'd1;
  localparam time_t RST_SPACE_HIGH  = 16'd227;
  localparam time_t RST_SPACE_LOW   = 16'd227;
  localparam time_t RST_SPACE_CYC   = 16'd2;

  // Request modes.
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // One tone's timing plus values derived from it.
  typedef struct packed {
    time_t high;
    time_t low;
    time_t cycles;
    logic  nonempty;   // tone produces at least one tick
    logic  start_low;  // high phase is empty, a cycle opens in the low phase
    time_t start_time; // length of the first non-empty phase of a cycle
  } tone_t;

  // Result of the next-bit search.
  typedef struct packed {
    logic     found;
    bit_idx_t idx;
  } find_t;

  // One result item.
  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic load_refused;
  } res_t;

endpackage

### rtl/fswt_cfg_regs.sv
// Configuration registers of the FSK transmitter and the per-tone derived values.
// Depends on fswt_pkg.
module fswt_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  fswt_pkg::cfg_idx_t wr_idx_i,
  input  fswt_pkg::time_t    wr_data_i,
  output fswt_pkg::tone_t    mark_o,
  output fswt_pkg::tone_t    space_o
);

  fswt_pkg::time_t mark_high_q, mark_low_q, mark_cyc_q;
  fswt_pkg::time_t space_high_q, space_low_q, space_cyc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_high_q  <= fswt_pkg::RST_MARK_HIGH;
      mark_low_q   <= fswt_pkg::RST_MARK_LOW;
      mark_cyc_q   <= fswt_pkg::RST_MARK_CYCLES;
      space_high_q <= fswt_pkg::RST_SPACE_HIGH;
      space_low_q  <= fswt_pkg::RST_SPACE_LOW;
      space_cyc_q  <= fswt_pkg::RST_SPACE_CYC;
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        fswt_pkg::REG_MARK_HIGH:   mark_high_q  <= wr_data_i;
        fswt_pkg::REG_MARK_LOW:    mark_low_q   <= wr_data_i;
        fswt_pkg::REG_MARK_CYCLES: mark_cyc_q   <= wr_data_i;
        fswt_pkg::REG_SPACE_HIGH:  space_high_q <= wr_data_i;
        fswt_pkg::REG_SPACE_LOW:   space_low_q  <= wr_data_i;
        fswt_pkg::REG_SPACE_CYC:   space_cyc_q  <= wr_data_i;
        default: ; // Writes beyond the register list are dropped.
      endcase
    end
  end

  always_comb begin
    mark_o.high       = mark_high_q;
    mark_o.low        = mark_low_q;
    mark_o.cycles     = mark_cyc_q;
    mark_o.nonempty   = (mark_cyc_q != '0) && ((mark_high_q | mark_low_q) != '0);
    mark_o.start_low  = (mark_high_q == '0);
    mark_o.start_time = (mark_high_q == '0) ? mark_low_q : mark_high_q;

    space_o.high       = space_high_q;
    space_o.low        = space_low_q;
    space_o.cycles     = space_cyc_q;
    space_o.nonempty   = (space_cyc_q != '0) && ((space_high_q | space_low_q) != '0);
    space_o.start_low  = (space_high_q == '0);
    space_o.start_time = (space_high_q == '0) ? space_low_q : space_high_q;
  end

endmodule

### rtl/fswt_bit_find.sv
// Finds the most significant bit below a bound whose tone is not empty.
// Depends on fswt_pkg.
module fswt_bit_find (
  input  logic [fswt_pkg::BITS_PER_SYMBOL-1:0] bits_i,
  input  fswt_pkg::bound_t                     bound_i,
  input  logic                                 mark_ne_i,
  input  logic                                 space_ne_i,
  output fswt_pkg::find_t                      find_o
);

  logic [fswt_pkg::BITS_PER_SYMBOL-1:0] cand;

  always_comb begin
    for (int k = 0; k < fswt_pkg::BITS_PER_SYMBOL; k++) begin
      cand[k] = (bits_i[k] ? space_ne_i : mark_ne_i) &&
                (fswt_pkg::BOUND_W'(k) < bound_i);
    end
  end

  // Higher candidates overwrite lower ones, so the highest one wins.
  always_comb begin
    find_o.found = |cand;
    find_o.idx   = '0;
    for (int k = 0; k < fswt_pkg::BITS_PER_SYMBOL; k++) begin
      if (cand[k]) begin
        find_o.idx = fswt_pkg::BIT_IDX_W'(k);
      end
    end
  end

endmodule

### rtl/fswt_core.sv
// Transmit state of the FSK modulator: bit, cycle and phase counters and the result logic.
// Depends on fswt_pkg and fswt_bit_find.
module fswt_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic                                 mode_i,
  input  logic [fswt_pkg::BITS_PER_SYMBOL-1:0] data_i,
  input  fswt_pkg::tone_t                      mark_i,
  input  fswt_pkg::tone_t                      space_i,
  output fswt_pkg::res_t                       res_o
);

  logic [fswt_pkg::BITS_PER_SYMBOL-1:0] shift_q, shift_d;
  fswt_pkg::bit_idx_t                   bit_q, bit_d;
  fswt_pkg::time_t                      cyc_q, cyc_d;
  logic                                 low_q, low_d;
  fswt_pkg::time_t                      ptl_q, ptl_d;
  logic                                 active_q, active_d;

  logic                                 is_load;
  logic [fswt_pkg::BITS_PER_SYMBOL-1:0] search_bits;
  fswt_pkg::bound_t                     search_bound;
  fswt_pkg::find_t                      find;
  fswt_pkg::tone_t                      cur_tone, new_tone;
  fswt_pkg::time_t                      ptl_dec, cyc_dec;

  assign is_load = (mode_i == fswt_pkg::MODE_LOAD);

  // A load searches the whole new byte, a tick searches the bits below the current one.
  assign search_bits  = is_load ? data_i : shift_q;
  assign search_bound = is_load ? fswt_pkg::BOUND_W'(fswt_pkg::BITS_PER_SYMBOL)
                                : {1'b0, bit_q};

  fswt_bit_find u_bit_find (
    .bits_i     (search_bits),
    .bound_i    (search_bound),
    .mark_ne_i  (mark_i.nonempty),
    .space_ne_i (space_i.nonempty),
    .find_o     (find)
  );

  assign cur_tone = shift_q[bit_q] ? space_i : mark_i;
  assign new_tone = search_bits[find.idx] ? space_i : mark_i;
  assign ptl_dec  = ptl_q - 1'b1;
  assign cyc_dec  = cyc_q - 1'b1;

  always_comb begin
    shift_d  = shift_q;
    bit_d    = bit_q;
    cyc_d    = cyc_q;
    low_d    = low_q;
    ptl_d    = ptl_q;
    active_d = active_q;
    res_o    = '0;

    if (!is_load) begin
      if (active_q) begin
        res_o.pin_level = !low_q;
        res_o.busy_res  = 1'b1;
        if (ptl_dec != '0) begin
          ptl_d = ptl_dec;
        end else if (!low_q && (cur_tone.low != '0)) begin
          low_d = 1'b1;
          ptl_d = cur_tone.low;
        end else if ((cyc_dec != '0) && ((cur_tone.high | cur_tone.low) != '0)) begin
          cyc_d = cyc_dec;
          low_d = cur_tone.start_low;
          ptl_d = cur_tone.start_time;
        end else if (find.found) begin
          bit_d = find.idx;
          cyc_d = new_tone.cycles;
          low_d = new_tone.start_low;
          ptl_d = new_tone.start_time;
        end else begin
          active_d = 1'b0;
        end
      end
    end else if (active_q) begin
      res_o.load_refused = 1'b1;
      res_o.busy_res     = 1'b1;
      res_o.pin_level    = !low_q;
    end else begin
      shift_d  = data_i;
      active_d = find.found;
      if (find.found) begin
        bit_d = find.idx;
        cyc_d = new_tone.cycles;
        low_d = new_tone.start_low;
        ptl_d = new_tone.start_time;
      end
      res_o.busy_res  = find.found;
      res_o.pin_level = find.found && !new_tone.start_low;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= '0;
      bit_q    <= fswt_pkg::BIT_IDX_W'(fswt_pkg::BITS_PER_SYMBOL - 1);
      cyc_q    <= '0;
      low_q    <= 1'b0;
      ptl_q    <= '0;
      active_q <= 1'b0;
    end else if (accept_i) begin
      shift_q  <= shift_d;
      bit_q    <= bit_d;
      cyc_q    <= cyc_d;
      low_q    <= low_d;
      ptl_q    <= ptl_d;
      active_q <= active_d;
    end
  end

endmodule

### rtl/fsk_square_wave_transmitter_top.sv
// Top level of the binary FSK square-wave transmitter.
// Depends on fswt_pkg, fswt_cfg_regs, fswt_core and fswt_bit_find.
//
// Usage:
// The input channel carries one request per microsecond tick (mode 0) or a
// byte load (mode 1). The byte is sent most significant bit first; a 0 bit
// sends the mark tone and a 1 bit the space tone, each as a whole number of
// square-wave cycles timed by the configuration registers.
// Every request produces exactly one result on the output channel: the pin
// level for that tick, the busy flag and a flag that marks a refused load.
// A load that arrives while a byte is still going out is dropped.
// The result of an accepted request is registered in the output buffer.
// Throughput is one request per cycle while in_ready_o is high; the transmit
// counters are updated in a single pass between the state registers and the
// result register, so back-to-back requests never wait on each other.
// The output has a two-entry skid buffer, so one more request is taken while
// a result waits. When the receiver stalls with both entries full, in_ready_o
// drops until a result is taken.
// The configuration port is always ready and should be written only while
// no request is in flight. A write during a byte leaves the running phase
// alone; later phases use the new lengths and the next bit the new cycle count.
// Reset restores the register defaults, puts the block in the idle state, in
// which ticks report the pin low, and empties the output buffer.
module fsk_square_wave_transmitter_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write channel.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  fswt_pkg::cfg_idx_t                   cfg_index_i,
  input  fswt_pkg::time_t                      cfg_data_i,
  // Request channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 mode_i,
  input  logic [fswt_pkg::BITS_PER_SYMBOL-1:0] data_byte_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 pin_level_o,
  output logic                                 busy_res_o,
  output logic                                 load_refused_o
);

  fswt_pkg::tone_t mark, space;
  fswt_pkg::res_t  res_new;
  fswt_pkg::res_t  out_q, out_d, skid_q, skid_d;
  logic            out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic            in_accept, out_take;

  // The registers take a write whenever it is valid, so the port never stalls.
  assign cfg_ready_o = 1'b1;

  fswt_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .mark_o    (mark),
    .space_o   (space)
  );

  // A request is taken whenever the skid entry is free.
  assign in_ready_o = !skid_valid_q;
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_take   = out_valid_q && out_ready_i;

  fswt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .mode_i   (mode_i),
    .data_i   (data_byte_i),
    .mark_i   (mark),
    .space_i  (space),
    .res_o    (res_new)
  );

  // Output register plus skid entry. The skid entry is empty whenever a
  // request is accepted, so a new result goes to the output register if it
  // is free this cycle and otherwise parks in the skid entry.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (in_accept) begin
      if (!out_valid_q || out_take) begin
        out_d       = res_new;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_new;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pin_level_o    = out_q.pin_level;
  assign busy_res_o     = out_q.busy_res;
  assign load_refused_o = out_q.load_refused;

`ifndef SYNTHESIS
  // The skid entry only fills behind a waiting output result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output register is empty");

  // A refused load can only come from a busy transmitter.
  a_refused_is_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && load_refused_o) |-> busy_res_o)
    else $error("refused load reported while not busy");

  // The pin stays low whenever the transmitter is idle.
  a_idle_pin_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !busy_res_o) |-> !pin_level_o)
    else $error("pin high while idle");

  // A full buffer with a stalled receiver keeps both entries next cycle.
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_ready_i) |=> (skid_valid_q && out_valid_q))
    else $error("buffered result lost during a stall");
`endif

endmodule
